// ===== sv/wcs_pkg.sv =====
// Shared types and constants for the weighted count selector.
// Holds the input and result word layouts, codes and the control states.
// No dependencies.
package wcs_pkg;

  localparam int DRAW_W   = 54;
  localparam int RATE_W   = 32;
  localparam int ACTIVE_W = 7;
  localparam int INDEX_W  = 6;
  localparam int NEWCNT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [RATE_W-1:0]   RATE_RESET   = 32'd65536;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

  // Operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd1;

  typedef struct packed {
    logic                operation;
    logic [INDEX_W-1:0]  slot_index;
    logic [NEWCNT_W-1:0] new_count;
    logic [DRAW_W-1:0]   draw;
  } item_t;

  typedef struct packed {
    logic [DRAW_W-1:0]  propensity;
    logic [INDEX_W-1:0] chosen_slot;
    logic               found;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

// ===== sv/wcs_cell.sv =====
// One slot cell of the count ring: holds a slot count and takes its
// neighbor's count on every shift. Depends on nothing but its parameter.
module wcs_cell #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic [COUNT_WIDTH-1:0] count_in,
  output logic [COUNT_WIDTH-1:0] count
);

  // Clear at reset, take the neighbor's count on a shift, otherwise hold
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (shift) begin
      count <= count_in;
    end
  end

endmodule

// ===== sv/wcs_div.sv =====
// Restoring divider, one quotient bit per cycle: draw / rate.
// Uses wcs_pkg for the draw and rate widths.
module wcs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [wcs_pkg::DRAW_W-1:0] dividend,
  input  logic [wcs_pkg::RATE_W-1:0] divisor,
  output logic                      done,
  output logic [wcs_pkg::DRAW_W-1:0] quotient
);
  import wcs_pkg::*;

  localparam int STEP_W = $clog2(DRAW_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] dvsr;
  logic [RATE_W:0]   shifted;
  logic              ge;
  logic [RATE_W:0]   diff;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem, quotient[DRAW_W-1]};
    ge      = shifted >= {1'b0, dvsr};
    diff    = shifted - {1'b0, dvsr};
  end

  // Iterate over all dividend bits, quotient bits shift in from the right
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running  <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvsr     <= divisor;
        quotient <= dividend;
      end else if (running) begin
        rem      <= ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
        quotient <= {quotient[DRAW_W-2:0], ge};
        step     <= step + 1'b1;
        if (step == STEP_W'(DRAW_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/weighted_count_selector.sv =====
// Weighted count selector: roulette-wheel slot choice over a ring of count cells.
// Update: the result strobe follows one full ring turn.
// Select: a bit-serial divide, then a ring turn;
// with a zero rate both are skipped and nothing is found. One item at a time.
// Synchronous reset clears all slot counts and the total at once; registers
// return to rate 1.0 and all slots active. The receiver cannot stall results.
module weighted_count_selector #(
  parameter int MAX_SLOTS   = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  wcs_pkg::item_t                item,
  output logic                          result_valid,
  output wcs_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wcs_pkg::*;

  localparam int POS_W   = $clog2(MAX_SLOTS + 1);
  localparam int TOTAL_W = COUNT_WIDTH + $clog2(MAX_SLOTS + 1);

  state_t state;
  state_t state_next;

  logic [RATE_W-1:0]      rate;
  logic [ACTIVE_W-1:0]    active_slots;
  logic [TOTAL_W-1:0]     total;
  logic                   op;
  logic [INDEX_W-1:0]     idx;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [DRAW_W-1:0]      n;
  logic [POS_W-1:0]       pos;
  logic                   hit;
  logic [INDEX_W-1:0]     chosen;

  logic                   accept;
  logic                   div_go;
  logic                   div_done;
  logic [DRAW_W-1:0]      quotient;
  logic                   shift;
  logic [COUNT_WIDTH-1:0] head;
  logic [COUNT_WIDTH-1:0] head_new;
  logic                   idx_match;
  logic                   in_range;
  logic [31:0]            limit;
  logic [31:0]            pos_ext;
  logic [DRAW_W-1:0]      head_ext;
  logic [63:0]            product;

  logic [COUNT_WIDTH-1:0] cell_count [MAX_SLOTS];

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // Ring of count cells; slot 0 sits at the head while idle
  assign head     = cell_count[0];
  assign pos_ext  = 32'(pos);
  assign idx_match = (op == OP_UPDATE) && (pos_ext == 32'(idx));
  assign head_new = idx_match ? cnt : head;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic [COUNT_WIDTH-1:0] nbr;
    if (i == MAX_SLOTS - 1) begin : g_tail
      assign nbr = head_new;
    end else begin : g_mid
      assign nbr = cell_count[i+1];
    end
    wcs_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .count_in(nbr),
      .count   (cell_count[i])
    );
  end

  wcs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .dividend(item.draw),
    .divisor (rate),
    .done    (div_done),
    .quotient(quotient)
  );

  // Walk only the active slots, saturated at the ring size
  assign limit    = (32'(active_slots) > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS)
                                                         : 32'(active_slots);
  assign in_range = pos_ext < limit;
  assign head_ext = DRAW_W'(head);
  assign product  = 64'(rate) * 64'(total);

  // Next state and control
  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    shift      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.operation == OP_UPDATE) begin
            state_next = ST_WALK;
          end else if (rate == '0) begin
            state_next = ST_DONE;
          end else begin
            div_go     = 1'b1;
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        shift = 1'b1;
        if (pos == POS_W'(MAX_SLOTS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate         <= RATE_RESET;
      active_slots <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RATE:   rate         <= cfg_data[RATE_W-1:0];
        REG_ACTIVE: active_slots <= cfg_data[ACTIVE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Item datapath: latch the word, run the walk, drive the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      result_valid <= 1'b0;
      hit          <= 1'b0;
      pos          <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op     <= item.operation;
            idx    <= item.slot_index;
            cnt    <= COUNT_WIDTH'(item.new_count);
            pos    <= '0;
            hit    <= 1'b0;
            chosen <= '0;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            n <= quotient;
          end
        end
        ST_WALK: begin
          pos <= pos + 1'b1;
          if (idx_match) begin
            total <= total - TOTAL_W'(head) + TOTAL_W'(cnt);
          end
          if (op == OP_SELECT && !hit && in_range) begin
            if (n < head_ext) begin
              hit    <= 1'b1;
              chosen <= pos_ext[INDEX_W-1:0];
            end else begin
              n <= n - head_ext;
            end
          end
        end
        ST_DONE: begin
          result_valid       <= 1'b1;
          result.propensity  <= product[DRAW_W-1:0];
          result.chosen_slot <= hit ? chosen : '0;
          result.found       <= hit;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/weighted_count_selector_tb.sv =====
// Self-checking testbench for weighted_count_selector: a stimulus table, then phases of random
// update and select words, checked against table results or an in-bench slot table and sum.
// Depends on wcs_pkg and the weighted_count_selector RTL.
module weighted_count_selector_tb;
  import wcs_pkg::*;

  localparam int SLOT_COUNT = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 130;
  localparam int PHASES = 10;
  localparam int SHOWN_MISSES = 10;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    item_t                 word;
    bit                    typed;
    result_t               want;
  } step_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  item_t                 item;
  logic                  result_valid;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Mirror of the block state and registers
  logic [NEWCNT_W-1:0] slot_tally [SLOT_COUNT];
  logic [21:0]         tally_sum;
  logic [RATE_W-1:0]   cur_rate;
  logic [ACTIVE_W-1:0] cur_active;

  result_t   owed_q [$];
  result_t   due_word;
  step_row_t plan_q [$];
  int        idle_pct;
  int        mismatches;
  int        quiet;
  int        n_updates;
  int        n_selects;
  int        n_found;
  int        n_writes;

  weighted_count_selector dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one accepted word to the mirror and return the result it owes
  function automatic result_t weigh_word(input item_t w);
    result_t     r;
    logic [63:0] left;
    int          walk_end;
    r = '0;
    if (w.operation == OP_UPDATE) begin
      tally_sum = tally_sum - slot_tally[w.slot_index] + w.new_count;
      slot_tally[w.slot_index] = w.new_count;
    end else if (cur_rate != 0) begin
      left = 64'(w.draw) / 64'(cur_rate);
      walk_end = (cur_active > SLOT_COUNT) ? SLOT_COUNT : int'(cur_active);
      for (int i = 0; i < walk_end && !r.found; i++) begin
        if (left < 64'(slot_tally[i])) begin
          r.chosen_slot = i[INDEX_W-1:0];
          r.found = 1'b1;
        end else begin
          left = left - 64'(slot_tally[i]);
        end
      end
    end
    r.propensity = DRAW_W'(64'(cur_rate) * 64'(tally_sum));
    return r;
  endfunction

  // Build a random word: mostly updates and draws scaled to the wheel's total
  function automatic item_t roll_word();
    item_t       w;
    logic [95:0] noise;
    logic [63:0] span;
    int          pick;
    noise = {$urandom, $urandom, $urandom};
    w = noise[$bits(item_t)-1:0];
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      w.operation = OP_UPDATE;
      w.slot_index = $urandom_range(1, 0) ? INDEX_W'($urandom_range(7, 0))
                                          : INDEX_W'($urandom_range(63, 0));
      case ($urandom_range(3, 0))
        0: w.new_count = '0;
        1: w.new_count = '1;
        2: w.new_count = NEWCNT_W'($urandom_range(300, 1));
        default: w.new_count = NEWCNT_W'($urandom);
      endcase
    end else begin
      w.operation = OP_SELECT;
      if (pick < 90) begin
        span = 64'(cur_rate) * 64'($urandom_range(32'(tally_sum) + 2, 0));
        if (cur_rate != 0) span = span + 64'($urandom_range(cur_rate - 1, 0));
        w.draw = span[DRAW_W-1:0];
      end
    end
    return w;
  endfunction

  function automatic step_row_t op_row(input logic op, input int idx, input int cnt,
                                       input logic [DRAW_W-1:0] d, input bit typed,
                                       input logic [$bits(result_t)-1:0] want);
    step_row_t row;
    row.is_cfg = 1'b0;
    row.reg_sel = REG_RATE;
    row.reg_val = '0;
    row.word = {op, idx[INDEX_W-1:0], cnt[NEWCNT_W-1:0], d};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
                                        input logic [CFG_DATA_W-1:0] val);
    step_row_t row;
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    row.word = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // Offer one word until the block takes it, idling at random, then log what it owes
  task automatic send_word(input item_t w, input bit typed, input result_t want);
    bit      taken;
    result_t guess;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if ($urandom_range(99, 0) < idle_pct) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        item <= w;
      end
      @(posedge clk);
      taken = start && !busy;
    end
    guess = weigh_word(w);
    owed_q.push_back(typed ? want : guess);
    if (w.operation == OP_UPDATE) n_updates++;
    else n_selects++;
  endtask

  // Drop start, then write one register once every owed result has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    start <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (sel == REG_RATE) cur_rate = val;
    else if (sel == REG_ACTIVE) cur_active = val[ACTIVE_W-1:0];
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_result(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= SHOWN_MISSES)
      $display("%0t: %s: expected prop=%h slot=%0d found=%0d, got prop=%h slot=%0d found=%0d",
               $realtime, what, want.propensity, want.chosen_slot, want.found,
               got.propensity, got.chosen_slot, got.found);
  endtask

  // Score each result word against the oldest owed one
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (owed_q.size() == 0) begin
        flag_result("result with nothing owed", '0, result);
      end else begin
        due_word = owed_q.pop_front();
        if (due_word.propensity !== result.propensity ||
            due_word.chosen_slot !== result.chosen_slot ||
            due_word.found !== result.found)
          flag_result("result mismatch", due_word, result);
        else if (result.found)
          n_found++;
      end
    end
  end

  // Abort when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results owed",
                 QUIET_LIMIT, owed_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] phase_rate [PHASES];
    logic [ACTIVE_W-1:0]   phase_active [PHASES];
    int                    phase_items [PHASES];
    step_row_t             row;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RATE;
    cfg_data = '0;
    mismatches = 0;
    quiet = 0;
    n_updates = 0;
    n_selects = 0;
    n_found = 0;
    n_writes = 0;
    idle_pct = 11;
    foreach (slot_tally[i]) slot_tally[i] = '0;
    tally_sum = '0;
    cur_rate = RATE_RESET;
    cur_active = ACTIVE_RESET;

    // Directed table: empty wheel, extremes, walk ends, zero rate, no and extra slots
    plan_q.push_back(op_row(OP_SELECT, 0, 0, '0, 1, {54'h0, 6'd0, 1'b0}));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, '1, 1, {54'h0, 6'd0, 1'b0}));
    plan_q.push_back(op_row(OP_UPDATE, 0, 16'hFFFF, '0, 1, {54'hFFFF_0000, 6'd0, 1'b0}));
    plan_q.push_back(op_row(OP_UPDATE, 63, 16'hFFFF, '0, 1, {54'h1_FFFE_0000, 6'd0, 1'b0}));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, '0, 1, {54'h1_FFFE_0000, 6'd0, 1'b1}));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, 54'hFFFF_0000, 1,
                            {54'h1_FFFE_0000, 6'd63, 1'b1}));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, 54'h1_FFFD_FFFF, 0, '0));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, 54'h1_FFFE_0000, 1,
                            {54'h1_FFFE_0000, 6'd0, 1'b0}));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, '1, 0, '0));
    plan_q.push_back(op_row(OP_UPDATE, 5, 1, '0, 0, '0));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, 54'hFFFF_0000, 0, '0));
    plan_q.push_back(op_row(OP_UPDATE, 63, 0, '0, 0, '0));
    plan_q.push_back(op_row(OP_UPDATE, 0, 0, '0, 0, '0));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, 54'hFFFF, 0, '0));
    plan_q.push_back(cfg_row(REG_RATE, 32'd0));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, '0, 1, {54'h0, 6'd0, 1'b0}));
    plan_q.push_back(cfg_row(REG_RATE, 32'hFFFF_FFFF));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, '0, 0, '0));
    plan_q.push_back(cfg_row(REG_ACTIVE, 32'd0));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, '0, 0, '0));
    plan_q.push_back(cfg_row(REG_ACTIVE, 32'd127));
    plan_q.push_back(op_row(OP_UPDATE, 63, 16'hFFFF, '0, 0, '0));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, '1, 0, '0));
    plan_q.push_back(op_row(OP_SELECT, 0, 0, 54'h3F_FFFF_FFFF_FFFF, 0, '0));

    // Register settings for the random phases
    phase_rate = '{32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0,
                   32'h0000_8000, 32'd0, 32'h0001_0000, 32'd0, 32'h1234_5678};
    phase_active = '{7'd64, 7'd64, 7'd127, 7'd64, 7'd0, 7'd1, 7'd0, 7'd32, 7'd64, 7'd65};
    phase_items = '{80, 80, 80, 40, 60, 80, 80, 80, 80, 80};
    phase_rate[4] = $urandom;
    phase_rate[6] = $urandom;
    phase_rate[8] = $urandom_range(32'h0010_0000, 1);
    phase_active[6] = ACTIVE_W'($urandom_range(127, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    while (plan_q.size() != 0) begin
      row = plan_q.pop_front();
      if (row.is_cfg) write_reg(row.reg_sel, row.reg_val);
      else send_word(row.word, row.typed, row.want);
    end
    write_reg(REG_RATE, RATE_RESET);
    write_reg(REG_ACTIVE, 32'(ACTIVE_RESET));

    // Random phases: sender idles lightly, then heavily, then never
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p < 3) ? 11 : (p < 6) ? 71 : 0;
      write_reg(REG_RATE, phase_rate[p]);
      write_reg(REG_ACTIVE, 32'(phase_active[p]));
      for (int n = 0; n < phase_items[p]; n++) send_word(roll_word(), 1'b0, '0);
    end

    // Drain, then allow the block's latency for stray results
    @(negedge clk);
    start <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d updates and %0d selects (%0d hits) over %0d register writes.",
             n_updates, n_selects, n_found, n_writes);
    $display("Mismatches: %0d, results still owed: %0d.", mismatches, owed_q.size());
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
